// File: hw/rtl/lje_pkg.sv
`default_nettype none
package lje_pkg;

  localparam int unsigned CATEGORIES    = 17;
  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned CAT_W         = 5;
  localparam int unsigned LEN_W         = 5;
  localparam int unsigned CODE_W        = 16;
  localparam int unsigned DEPTH_W       = 5;
  localparam int unsigned CHUNK_LEN_W   = 6;
  localparam int unsigned CHUNK_W       = 32;
  localparam int unsigned TABLE_ENTRIES = 2 * CATEGORIES;
  localparam int unsigned ADDR_W        = $clog2(TABLE_ENTRIES);

  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd16;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX   = 5'd16;
  localparam logic [DEPTH_W-1:0] DEPTH_MIN   = 5'd1;
  localparam logic [CAT_W-1:0]   CAT_ZERO    = 5'd0;
  localparam logic [CAT_W-1:0]   CAT_MAX     = 5'd16;
  localparam logic [LEN_W-1:0]   LEN_MAX     = 5'd16;

  localparam logic ACT_ENCODE = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;

  typedef struct packed {
    logic                is_load;
    logic [SAMPLE_W-1:0] diff0;
    logic [SAMPLE_W-1:0] diff1;
    logic                tsel;
    logic [CAT_W-1:0]    tcat;
    logic [LEN_W-1:0]    elen;
    logic [CODE_W-1:0]   ecode;
  } work_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [ADDR_W-1:0] entry_addr(input logic tsel,
                                                   input logic [CAT_W-1:0] cat);
    logic [ADDR_W-1:0] base;
    base = tsel ? ADDR_W'(CATEGORIES) : '0;
    return base + ADDR_W'(cat);
  endfunction

  function automatic logic [CAT_W-1:0] category(input logic [SAMPLE_W-1:0] diff);
    logic [SAMPLE_W-1:0] mag;
    logic [CAT_W-1:0]    c;
    mag = diff[SAMPLE_W-1] ? (~diff + 1'b1) : diff;
    c = '0;
    for (int i = 0; i < SAMPLE_W; i++) begin
      if (mag[i]) begin
        c = CAT_W'(i + 1);
      end
    end
    return c;
  endfunction

  function automatic logic [SAMPLE_W-1:0] extra_bits(input logic [SAMPLE_W-1:0] diff,
                                                     input logic [CAT_W-1:0] cat);
    logic [SAMPLE_W-1:0] data;
    logic [SAMPLE_W-1:0] mask;
    data = diff[SAMPLE_W-1] ? (diff - 1'b1) : diff;
    mask = SAMPLE_W'((17'(1) << cat) - 17'(1));
    if (cat == CAT_ZERO || cat == CAT_MAX) begin
      return '0;
    end
    return data & mask;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/lje_in_if.sv
`default_nettype none
interface lje_in_if;
  logic                              valid;
  logic                              ready;
  logic                              action;
  logic [lje_pkg::SAMPLE_W-1:0]      first_sample;
  logic [lje_pkg::SAMPLE_W-1:0]      second_sample;
  logic                              row_begin;
  logic                              image_begin;
  logic                              zero_fill;
  logic                              table_choice;
  logic [lje_pkg::CAT_W-1:0]         table_category;
  logic [lje_pkg::LEN_W-1:0]         entry_length;
  logic [lje_pkg::CODE_W-1:0]        entry_code;

  modport source (
    output valid, action, first_sample, second_sample, row_begin, image_begin,
           zero_fill, table_choice, table_category, entry_length, entry_code,
    input  ready
  );

  modport sink (
    input  valid, action, first_sample, second_sample, row_begin, image_begin,
           zero_fill, table_choice, table_category, entry_length, entry_code,
    output ready
  );
endinterface
`default_nettype wire

// File: hw/rtl/lje_out_if.sv
`default_nettype none
interface lje_out_if;
  logic                              valid;
  logic                              ready;
  logic                              channel;
  logic [lje_pkg::CHUNK_LEN_W-1:0]   chunk_length;
  logic [lje_pkg::CHUNK_W-1:0]       chunk_bits;
  logic                              last;

  modport source (
    output valid, channel, chunk_length, chunk_bits, last,
    input  ready
  );

  modport sink (
    input  valid, channel, chunk_length, chunk_bits, last,
    output ready
  );
endinterface
`default_nettype wire

// File: hw/rtl/lje_front.sv
`default_nettype none
module lje_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [lje_pkg::DEPTH_W-1:0]   cfg_wdata,
  lje_in_if.sink                             in_ch,
  input  wire lje_pkg::q_status_t            q_status,
  output logic                               push,
  output lje_pkg::work_t                     push_data
);

  logic [lje_pkg::DEPTH_W-1:0]  depth_r;
  logic [lje_pkg::SAMPLE_W-1:0] left0_r, left1_r, above0_r, above1_r;
  logic [lje_pkg::DEPTH_W-1:0]  depth_c;
  logic [3:0]                   mid_shift;
  logic [lje_pkg::SAMPLE_W-1:0] midpoint;
  logic [lje_pkg::SAMPLE_W-1:0] pa0, pa1, p0, p1;
  logic                         accept;
  logic                         encode;
  logic                         update;
  logic [lje_pkg::LEN_W-1:0]    elen_c;
  logic [lje_pkg::CODE_W-1:0]   code_mask;

  assign in_ch.ready = !q_status.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign encode      = (in_ch.action == lje_pkg::ACT_ENCODE);
  assign update      = accept && encode && !in_ch.zero_fill;

  always_comb begin
    if (depth_r < lje_pkg::DEPTH_MIN) begin
      depth_c = lje_pkg::DEPTH_MIN;
    end else if (depth_r > lje_pkg::DEPTH_MAX) begin
      depth_c = lje_pkg::DEPTH_MAX;
    end else begin
      depth_c = depth_r;
    end
    mid_shift = 4'(depth_c - lje_pkg::DEPTH_MIN);
    midpoint  = lje_pkg::SAMPLE_W'(1) << mid_shift;
  end

  always_comb begin
    pa0 = (in_ch.image_begin) ? midpoint : above0_r;
    pa1 = (in_ch.image_begin) ? midpoint : above1_r;
    p0  = in_ch.row_begin ? pa0 : left0_r;
    p1  = in_ch.row_begin ? pa1 : left1_r;
  end

  always_comb begin
    elen_c    = (in_ch.entry_length > lje_pkg::LEN_MAX) ? lje_pkg::LEN_MAX : in_ch.entry_length;
    code_mask = lje_pkg::CODE_W'((17'(1) << elen_c) - 17'(1));
  end

  always_comb begin
    push_data.is_load = (in_ch.action == lje_pkg::ACT_LOAD);
    push_data.diff0   = in_ch.zero_fill ? '0 : (in_ch.first_sample - p0);
    push_data.diff1   = in_ch.zero_fill ? '0 : (in_ch.second_sample - p1);
    push_data.tsel    = in_ch.table_choice;
    push_data.tcat    = in_ch.table_category;
    push_data.elen    = elen_c;
    push_data.ecode   = in_ch.entry_code & code_mask;
    push = accept &&
           (encode || (in_ch.table_category < lje_pkg::CAT_W'(lje_pkg::CATEGORIES)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r  <= lje_pkg::DEPTH_RESET;
      left0_r  <= '0;
      left1_r  <= '0;
      above0_r <= '0;
      above1_r <= '0;
    end else begin
      if (cfg_we) begin
        depth_r <= cfg_wdata;
      end
      if (update) begin
        left0_r <= in_ch.first_sample;
        left1_r <= in_ch.second_sample;
        if (in_ch.row_begin) begin
          above0_r <= in_ch.first_sample;
          above1_r <= in_ch.second_sample;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/lje_queue.sv
`default_nettype none
module lje_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire lje_pkg::work_t      push_data,
  input  wire logic                pop,
  output lje_pkg::work_t           head,
  output lje_pkg::q_status_t       status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lje_pkg::work_t     slots_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign head         = slots_r[rd_ptr_r];
  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!status.full || pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("queue pop while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule
`default_nettype wire

// File: hw/rtl/lje_back.sv
`default_nettype none
module lje_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lje_pkg::work_t      head,
  input  wire lje_pkg::q_status_t  q_status,
  output logic                     pop,
  lje_out_if.source                out_ch
);

  lje_pkg::entry_t               table_r [lje_pkg::TABLE_ENTRIES];
  lje_pkg::entry_t               rd_r;
  logic                          sub_r, sub_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          chan_r;
  logic [lje_pkg::CAT_W-1:0]     cat_r;
  logic [lje_pkg::SAMPLE_W-1:0]  data_r;
  logic                          head_valid;
  logic                          do_load;
  logic                          issue;
  logic                          stage_free;
  logic [lje_pkg::SAMPLE_W-1:0]  cur_diff;
  logic [lje_pkg::CAT_W-1:0]     cur_cat;
  logic [lje_pkg::CAT_W-1:0]     ext;

  assign head_valid = !q_status.empty;
  assign stage_free = !out_valid_r || out_ch.ready;
  assign do_load    = head_valid && head.is_load;
  assign issue      = head_valid && !head.is_load && stage_free;
  assign pop        = do_load || (issue && sub_r);
  assign cur_diff   = sub_r ? head.diff1 : head.diff0;
  assign cur_cat    = lje_pkg::category(cur_diff);

  always_comb begin
    sub_nxt       = issue ? !sub_r : sub_r;
    out_valid_nxt = issue || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sub_r       <= sub_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      table_r[lje_pkg::entry_addr(head.tsel, head.tcat)] <= {head.elen, head.ecode};
    end
    if (issue) begin
      rd_r   <= table_r[lje_pkg::entry_addr(sub_r, cur_cat)];
      chan_r <= sub_r;
      cat_r  <= cur_cat;
      data_r <= lje_pkg::extra_bits(cur_diff, cur_cat);
    end
  end

  always_comb begin
    ext = (cat_r == lje_pkg::CAT_ZERO || cat_r == lje_pkg::CAT_MAX) ? '0 : cat_r;
    out_ch.valid        = out_valid_r;
    out_ch.channel      = chan_r;
    out_ch.last         = chan_r;
    out_ch.chunk_length = lje_pkg::CHUNK_LEN_W'(rd_r.len) + lje_pkg::CHUNK_LEN_W'(ext);
    out_ch.chunk_bits   = (lje_pkg::CHUNK_W'(rd_r.code) << ext) |
                          lje_pkg::CHUNK_W'(data_r);
  end

  a_second_chunk_src: assert property (@(posedge clk) disable iff (!rst_n)
    sub_r |-> (head_valid && !head.is_load))
    else $error("second chunk pending without an encode request at head");

  a_pop_with_head: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop without a request at head");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_ch.chunk_length <= lje_pkg::CHUNK_LEN_W'(lje_pkg::CHUNK_W)))
    else $error("chunk length above word width");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && !sub_r) |=> sub_r)
    else $error("first chunk not followed by second");

endmodule
`default_nettype wire

// File: hw/rtl/lossless_jpeg_pair_diff_encoder.sv
// An accepted pair passes a queue slot and the registered table read to its channel 0 chunk,
//   then channel 1, and is popped once both are issued; one table load per cycle if no pair
//   waits ahead. The single result port and the one table read per cycle set the pair rate.
// A request queue of QUEUE_DEPTH entries lets the input run ahead of a stalled output.
// Reset (rst_n, synchronous, active low): predictors to 0, sample_depth to 16, queue
//   and output empty; Huffman table contents are not cleared and must be loaded.
`default_nettype none
module lossless_jpeg_pair_diff_encoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [lje_pkg::DEPTH_W-1:0]   cfg_wdata,
  lje_in_if.sink                             in_ch,
  lje_out_if.source                          out_ch
);

  lje_pkg::work_t     push_data;
  lje_pkg::work_t     head;
  lje_pkg::q_status_t q_status;
  logic               push;
  logic               pop;

  lje_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  lje_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  lje_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

// File: verif/tb_lossless_jpeg_pair_diff_encoder.sv
`default_nettype none
module tb_lossless_jpeg_pair_diff_encoder;
  import lje_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 1400;
  localparam longint TIMEOUT   = 64'd20_000_000;

  typedef struct packed {
    logic                action;
    logic [SAMPLE_W-1:0] s0;
    logic [SAMPLE_W-1:0] s1;
    logic                row_begin;
    logic                image_begin;
    logic                zero_fill;
    logic                tsel;
    logic [CAT_W-1:0]    tcat;
    logic [LEN_W-1:0]    elen;
    logic [CODE_W-1:0]   ecode;
  } pair_req_t;

  typedef struct packed {
    logic                   channel;
    logic [CHUNK_LEN_W-1:0] length;
    logic [CHUNK_W-1:0]     bits;
    logic                   last;
  } chunk_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [DEPTH_W-1:0]  cfg_wdata;

  lje_in_if  in_ch();
  lje_out_if out_ch();

  lossless_jpeg_pair_diff_encoder u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  logic [SAMPLE_W-1:0] left_first, left_second, above_first, above_second;
  logic [LEN_W-1:0]    code_len  [2][CATEGORIES];
  logic [CODE_W-1:0]   code_word [2][CATEGORIES];
  logic [DEPTH_W-1:0]  depth_reg;
  chunk_t              expected_chunks[$];
  int                  errors = 0;
  bit                  no_idle = 1'b0;
  int                  stall_left = 0;

  always #HALF_PERIOD clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic chunk_t encode_chunk(input logic ch, input logic [SAMPLE_W-1:0] diff);
    logic [SAMPLE_W:0]      mag;
    logic [CAT_W-1:0]       cat;
    logic [SAMPLE_W-1:0]    data;
    logic [CHUNK_W-1:0]     bits;
    logic [CHUNK_LEN_W-1:0] len;
    chunk_t                 c;
    mag = diff[SAMPLE_W-1] ? (17'h10000 - {1'b0, diff}) : {1'b0, diff};
    cat = '0;
    for (int i = 0; i < SAMPLE_W; i++) begin
      if (mag[i]) cat = CAT_W'(i + 1);
    end
    len  = CHUNK_LEN_W'(code_len[ch][cat]);
    bits = CHUNK_W'(code_word[ch][cat]);
    if (cat != CAT_ZERO && cat != CAT_MAX) begin
      data = diff[SAMPLE_W-1] ? (diff - 1'b1) : diff;
      bits = (bits << cat) | CHUNK_W'(data & ((SAMPLE_W'(1) << cat) - 1'b1));
      len  = len + cat;
    end
    c.channel = ch;
    c.length  = len;
    c.bits    = bits;
    c.last    = ch;
    return c;
  endfunction

  task automatic advance_encoder(input pair_req_t r);
    logic [SAMPLE_W-1:0] p0, p1;
    logic [LEN_W-1:0]    len;
    logic [DEPTH_W-1:0]  dep;
    if (r.action == ACT_LOAD) begin
      if (r.tcat < CATEGORIES) begin
        len = (r.elen > LEN_MAX) ? LEN_MAX : r.elen;
        code_len[r.tsel][r.tcat]  = len;
        code_word[r.tsel][r.tcat] = r.ecode & CODE_W'((17'd1 << len) - 17'd1);
      end
    end else if (r.zero_fill) begin
      expected_chunks.push_back(encode_chunk(1'b0, '0));
      expected_chunks.push_back(encode_chunk(1'b1, '0));
    end else begin
      if (r.row_begin) begin
        if (r.image_begin) begin
          dep = depth_reg;
          if (dep < DEPTH_MIN) dep = DEPTH_MIN;
          if (dep > DEPTH_MAX) dep = DEPTH_MAX;
          above_first  = SAMPLE_W'(1) << (dep - 1'b1);
          above_second = above_first;
        end
        p0 = above_first;
        p1 = above_second;
        above_first  = r.s0;
        above_second = r.s1;
      end else begin
        p0 = left_first;
        p1 = left_second;
      end
      expected_chunks.push_back(encode_chunk(1'b0, r.s0 - p0));
      expected_chunks.push_back(encode_chunk(1'b1, r.s1 - p1));
      left_first  = r.s0;
      left_second = r.s1;
    end
  endtask

  task automatic send_request(input pair_req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.action         <= r.action;
    in_ch.first_sample   <= r.s0;
    in_ch.second_sample  <= r.s1;
    in_ch.row_begin      <= r.row_begin;
    in_ch.image_begin    <= r.image_begin;
    in_ch.zero_fill      <= r.zero_fill;
    in_ch.table_choice   <= r.tsel;
    in_ch.table_category <= r.tcat;
    in_ch.entry_length   <= r.elen;
    in_ch.entry_code     <= r.ecode;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    advance_encoder(r);
  endtask

  task automatic drain_chunks();
    in_ch.valid <= 1'b0;
    while (expected_chunks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_depth(input logic [DEPTH_W-1:0] value);
    drain_chunks();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    depth_reg = value;
  endtask

  function automatic pair_req_t random_fields();
    pair_req_t r;
    r.action      = 1'($urandom);
    r.s0          = SAMPLE_W'($urandom);
    r.s1          = SAMPLE_W'($urandom);
    r.row_begin   = 1'($urandom);
    r.image_begin = 1'($urandom);
    r.zero_fill   = 1'($urandom);
    r.tsel        = 1'($urandom);
    r.tcat        = CAT_W'($urandom);
    r.elen        = LEN_W'($urandom);
    r.ecode       = CODE_W'($urandom);
    return r;
  endfunction

  function automatic pair_req_t load_req(input logic tsel, input logic [CAT_W-1:0] tcat,
                                         input logic [LEN_W-1:0] elen,
                                         input logic [CODE_W-1:0] ecode);
    pair_req_t r;
    r = random_fields();
    r.action = ACT_LOAD;
    r.tsel   = tsel;
    r.tcat   = tcat;
    r.elen   = elen;
    r.ecode  = ecode;
    return r;
  endfunction

  function automatic pair_req_t pair_req(input logic [SAMPLE_W-1:0] s0,
                                         input logic [SAMPLE_W-1:0] s1,
                                         input logic row_begin, input logic image_begin,
                                         input logic zero_fill);
    pair_req_t r;
    r = random_fields();
    r.action      = ACT_ENCODE;
    r.s0          = s0;
    r.s1          = s1;
    r.row_begin   = row_begin;
    r.image_begin = image_begin;
    r.zero_fill   = zero_fill;
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] prev);
    int unsigned k, d;
    case ($urandom_range(0, 7))
      0: return SAMPLE_W'($urandom);
      1: return '0;
      2: return '1;
      default: begin
        k = $urandom_range(0, 15);
        d = $urandom & ((32'd1 << k) - 1);
        return $urandom_range(0, 1) ? SAMPLE_W'(prev + d) : SAMPLE_W'(prev - d);
      end
    endcase
  endfunction

  always @(posedge clk) begin : chunk_check
    chunk_t want;
    int     gap;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_chunks.size() == 0) begin
        errors++;
        $display("%0t: unexpected chunk: expected none, actual ch=%0d len=%0d bits=%h last=%0d",
                 $time, out_ch.channel, out_ch.chunk_length, out_ch.chunk_bits, out_ch.last);
      end else begin
        want = expected_chunks.pop_front();
        if (out_ch.channel !== want.channel) begin
          errors++;
          $display("%0t: channel: expected %0d actual %0d", $time, want.channel, out_ch.channel);
        end
        if (out_ch.chunk_length !== want.length) begin
          errors++;
          $display("%0t: chunk_length: expected %0d actual %0d", $time, want.length,
                   out_ch.chunk_length);
        end
        if (out_ch.chunk_bits !== want.bits) begin
          errors++;
          $display("%0t: chunk_bits: expected %h actual %h", $time, want.bits,
                   out_ch.chunk_bits);
        end
        if (out_ch.last !== want.last) begin
          errors++;
          $display("%0t: last: expected %0d actual %0d", $time, want.last, out_ch.last);
        end
      end
    end
    if (no_idle) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      gap = pick_gap();
      if (gap > 0) begin
        stall_left = gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic test_table_load();
    for (int t = 0; t < 2; t++) begin
      for (int c = 0; c < CATEGORIES; c++) begin
        send_request(load_req(1'(t), CAT_W'(c), LEN_W'($urandom_range(0, 16)),
                              CODE_W'($urandom)));
      end
    end
    // saturate long lengths, mask stray code bits, drop bad categories
    send_request(load_req(1'b0, CAT_MAX, 5'd31, 16'hFFFF));
    send_request(load_req(1'b1, CAT_ZERO, 5'd17, 16'hFFFF));
    send_request(load_req(1'b0, 5'd1, 5'd0, 16'hFFFF));
    send_request(load_req(1'b1, 5'd3, 5'd4, 16'hFFFF));
    send_request(load_req(1'b0, 5'd31, 5'd5, 16'h1234));
    send_request(load_req(1'b1, 5'd17, 5'd16, 16'hABCD));
  endtask

  task automatic test_directed_pairs();
    send_request(pair_req(16'd100, 16'd200, 1'b0, 1'b0, 1'b0));
    send_request(pair_req(16'h8000, 16'h0000, 1'b1, 1'b1, 1'b0));
    send_request(pair_req(16'hFFFF, 16'h7FFF, 1'b0, 1'b0, 1'b0));
    send_request(pair_req(16'hFFFE, 16'h8000, 1'b0, 1'b0, 1'b0));
    send_request(pair_req(16'h1234, 16'h5678, 1'b1, 1'b1, 1'b1));
    send_request(pair_req(16'h0000, 16'hFFFF, 1'b0, 1'b1, 1'b0));
    send_request(pair_req(16'h8000, 16'h0000, 1'b1, 1'b0, 1'b0));
    send_request(pair_req(16'h0000, 16'h8000, 1'b0, 1'b0, 1'b0));
    send_request(pair_req(16'h0001, 16'h8001, 1'b0, 1'b0, 1'b0));
  endtask

  task automatic test_depth_settings();
    logic [DEPTH_W-1:0] depths [9];
    logic [SAMPLE_W-1:0] s0, s1;
    depths = '{5'd0, 5'd1, 5'd2, 5'd7, 5'd15, 5'd31, 5'd17, 5'd8, 5'd16};
    foreach (depths[i]) begin
      write_depth(depths[i]);
      s0 = pick_sample(SAMPLE_W'(1) << (depths[i] == 0 ? 0 : (depths[i] > 16 ? 15 :
                                                                depths[i] - 1)));
      s1 = pick_sample(s0);
      send_request(pair_req(s0, s1, 1'b1, 1'b1, 1'b0));
      for (int j = 0; j < 3; j++) begin
        s0 = pick_sample(s0);
        s1 = pick_sample(s1);
        send_request(pair_req(s0, s1, 1'b0, 1'b0, 1'b0));
      end
    end
  endtask

  task automatic test_random_traffic();
    int                  items;
    int                  kind, rows, width, loads;
    logic [SAMPLE_W-1:0] prev0, prev1;
    pair_req_t           r;
    items = 0;
    prev0 = SAMPLE_W'($urandom);
    prev1 = SAMPLE_W'($urandom);
    while (items < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 99) < 15);
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        rows  = $urandom_range(1, 4);
        width = $urandom_range(1, 10);
        for (int row = 0; row < rows; row++) begin
          for (int col = 0; col < width; col++) begin
            if ($urandom_range(0, 19) == 0) begin
              r = random_fields();
              r.action    = ACT_ENCODE;
              r.zero_fill = 1'b1;
              send_request(r);
            end else begin
              prev0 = pick_sample(prev0);
              prev1 = pick_sample(prev1);
              send_request(pair_req(prev0, prev1, col == 0, row == 0 && col == 0, 1'b0));
            end
            items++;
          end
        end
      end else if (kind < 80) begin
        loads = $urandom_range(1, 6);
        for (int i = 0; i < loads; i++) begin
          r = load_req(1'($urandom), CAT_W'($urandom_range(0, 19) == 0 ? $urandom :
                                            $urandom_range(0, 16)),
                       LEN_W'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 16)),
                       CODE_W'($urandom));
          send_request(r);
          if (r.tcat < CATEGORIES) items++;
        end
      end else if (kind < 92) begin
        for (int i = 0; i < 4; i++) begin
          r = random_fields();
          send_request(r);
          if (r.action == ACT_ENCODE || r.tcat < CATEGORIES) items++;
        end
      end else if (kind < 96) begin
        drain_chunks();
      end else begin
        write_depth(DEPTH_W'($urandom));
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_wdata            <= DEPTH_RESET;
    in_ch.valid          <= 1'b0;
    in_ch.action         <= ACT_ENCODE;
    in_ch.first_sample   <= '0;
    in_ch.second_sample  <= '0;
    in_ch.row_begin      <= 1'b0;
    in_ch.image_begin    <= 1'b0;
    in_ch.zero_fill      <= 1'b0;
    in_ch.table_choice   <= 1'b0;
    in_ch.table_category <= '0;
    in_ch.entry_length   <= '0;
    in_ch.entry_code     <= '0;
    left_first   = '0;
    left_second  = '0;
    above_first  = '0;
    above_second = '0;
    depth_reg    = DEPTH_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_table_load();
    test_directed_pairs();
    test_depth_settings();
    test_random_traffic();

    drain_chunks();
    if (errors == 0) begin
      $display("[lossless_jpeg_pair_diff_encoder] OK");
    end else begin
      $display("[lossless_jpeg_pair_diff_encoder] ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT);
    $display("[lossless_jpeg_pair_diff_encoder] ERROR");
    $finish;
  end

endmodule
`default_nettype wire
